// ===== rtl/core/scpr_pkg.sv =====
// Package for the second-chance page replacement block.
// Holds the controller state type, the command and status structs and fixed constants.
// No dependencies.
package scpr_pkg;

	// Fixed field widths.
	localparam int CFG_WIDTH       = 5;
	localparam int FRAME_OUT_WIDTH = 4;
	localparam int FAULT_WIDTH     = 16;

	// Reset value of the frame count register.
	localparam logic [CFG_WIDTH-1:0] NUM_FRAMES_RESET = 5'd16;

	// The fault counter stops at this value.
	localparam logic [FAULT_WIDTH-1:0] FAULT_MAX = 16'hFFFF;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESOLVE,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // Latch the page and bring the hand into range.
		logic lookup;      // Register the result of the parallel compare.
		logic use_set;     // Hit: set the use bit of the matching frame.
		logic fault;       // Miss: bump the saturating fault counter.
		logic sweep_clear; // Clear the use bit under the hand and advance.
		logic load;        // Load the page under the hand and advance.
		logic emit;        // Move the finished result into the output register.
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;         // The registered lookup found the page.
		logic use_at_hand; // The use bit under the hand is set.
		logic out_free;    // The output register can take a result this cycle.
	} status_t;

endpackage

// ===== rtl/core/scpr_ctrl.sv =====
// Controller state machine for the second-chance page replacement block.
// Depends on scpr_pkg for the state type and the command and status structs.
module scpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  scpr_pkg::status_t status,
	output scpr_pkg::cmd_t    cmd
);

	scpr_pkg::state_t state_q;
	scpr_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			scpr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = scpr_pkg::ST_LOOKUP;
				end
			end
			scpr_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_next = scpr_pkg::ST_RESOLVE;
			end
			scpr_pkg::ST_RESOLVE: begin
				if (status.hit) begin
					cmd.use_set = 1'b1;
					state_next  = scpr_pkg::ST_EMIT;
				end else begin
					cmd.fault  = 1'b1;
					state_next = scpr_pkg::ST_SWEEP;
				end
			end
			scpr_pkg::ST_SWEEP: begin
				// Give each frame with its use bit set a second chance.
				if (status.use_at_hand) begin
					cmd.sweep_clear = 1'b1;
				end else begin
					cmd.load   = 1'b1;
					state_next = scpr_pkg::ST_EMIT;
				end
			end
			scpr_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					state_next = scpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = scpr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/scpr_dp.sv =====
// Datapath for the second-chance page replacement block: frame table, clock hand,
// fault counter and output register. Depends on scpr_pkg; driven by scpr_ctrl.
module scpr_dp #(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [scpr_pkg::CFG_WIDTH-1:0]      cfg_data,
	input  logic [PAGE_WIDTH-1:0]               page_in,
	input  scpr_pkg::cmd_t                      cmd,
	output scpr_pkg::status_t                   status,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                out_hit,
	output logic [scpr_pkg::FRAME_OUT_WIDTH-1:0] out_frame,
	output logic                                out_evicted_valid,
	output logic [PAGE_WIDTH-1:0]               out_evicted_page,
	output logic [scpr_pkg::FAULT_WIDTH-1:0]    out_fault_count
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);

	// Configuration and per-item state.
	logic [scpr_pkg::CFG_WIDTH-1:0]   num_frames_q;
	logic [PAGE_WIDTH-1:0]            page_q;
	logic [PAGE_WIDTH-1:0]            frame_page_q [FRAMES];
	logic [FRAMES-1:0]                valid_q;
	logic [FRAMES-1:0]                use_q;
	logic [IW-1:0]                    hand_q;
	logic [scpr_pkg::FAULT_WIDTH-1:0] faults_q;
	logic                             hit_q;
	logic [IW-1:0]                    slot_q;
	logic                             ev_valid_q;
	logic [PAGE_WIDTH-1:0]            ev_page_q;

	// Output register.
	logic                                 out_valid_q;
	logic                                 out_hit_q;
	logic [IW-1:0]                        out_slot_q;
	logic                                 out_ev_valid_q;
	logic [PAGE_WIDTH-1:0]                out_ev_page_q;
	logic [scpr_pkg::FAULT_WIDTH-1:0]     out_faults_q;
	logic [IW+scpr_pkg::FRAME_OUT_WIDTH-1:0] out_slot_ext;

	logic [NW-1:0]     n_c;
	logic [NW:0]       hand_inc;
	logic [IW-1:0]     hand_next;
	logic [FRAMES-1:0] match_c;
	logic              found_c;
	logic [IW-1:0]     found_idx_c;

	// Active frame count, with zero taken as one and large values clamped.
	always_comb begin
		if (num_frames_q == '0) begin
			n_c = NW'(1);
		end else if (32'(num_frames_q) > 32'(FRAMES)) begin
			n_c = NW'(FRAMES);
		end else begin
			n_c = NW'(num_frames_q);
		end
	end

	// Hand advance with wrap at the active frame count.
	always_comb begin
		hand_inc = (NW + 1)'(hand_q) + (NW + 1)'(1);
		if (hand_inc >= (NW + 1)'(n_c)) begin
			hand_next = '0;
		end else begin
			hand_next = IW'(hand_inc);
		end
	end

	// Parallel compare against all active, valid frames.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match_c[i] = valid_q[i] && (frame_page_q[i] == page_q) && (i < int'(n_c));
		end
	end

	// The lowest-numbered matching frame wins.
	always_comb begin
		found_c     = 1'b0;
		found_idx_c = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (match_c[i] && !found_c) begin
				found_c     = 1'b1;
				found_idx_c = IW'(i);
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= scpr_pkg::NUM_FRAMES_RESET;
		end else if (cfg_we) begin
			num_frames_q <= cfg_data;
		end
	end

	// Control state: valid and use bits, hand, fault counter, lookup flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			use_q    <= '0;
			hand_q   <= '0;
			faults_q <= '0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.accept && (32'(hand_q) >= 32'(n_c))) begin
				hand_q <= '0;
			end
			if (cmd.lookup) begin
				hit_q <= found_c;
			end
			if (cmd.use_set) begin
				use_q[slot_q] <= 1'b1;
			end
			if (cmd.fault && (faults_q != scpr_pkg::FAULT_MAX)) begin
				faults_q <= faults_q + 1'b1;
			end
			if (cmd.sweep_clear) begin
				use_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end
			if (cmd.load) begin
				valid_q[hand_q] <= 1'b1;
				use_q[hand_q]   <= 1'b1;
				hand_q          <= hand_next;
			end
		end
	end

	// Payload: page, frame table, matching slot and eviction data.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q     <= page_in;
			ev_valid_q <= 1'b0;
			ev_page_q  <= '0;
		end
		if (cmd.lookup) begin
			slot_q <= found_idx_c;
		end
		if (cmd.load) begin
			frame_page_q[hand_q] <= page_q;
			slot_q               <= hand_q;
			ev_valid_q           <= valid_q[hand_q];
			ev_page_q            <= valid_q[hand_q] ? frame_page_q[hand_q] : '0;
		end
	end

	// Output register: filled on emit, emptied when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_hit_q      <= hit_q;
			out_slot_q     <= slot_q;
			out_ev_valid_q <= ev_valid_q;
			out_ev_page_q  <= ev_page_q;
			out_faults_q   <= faults_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		status.hit         = hit_q;
		status.use_at_hand = use_q[hand_q];
		status.out_free    = !out_valid_q || !out_stall;
	end

	assign out_slot_ext      = {{scpr_pkg::FRAME_OUT_WIDTH{1'b0}}, out_slot_q};
	assign out_valid         = out_valid_q;
	assign out_hit           = out_hit_q;
	assign out_frame         = out_slot_ext[scpr_pkg::FRAME_OUT_WIDTH-1:0];
	assign out_evicted_valid = out_ev_valid_q;
	assign out_evicted_page  = out_ev_page_q;
	assign out_fault_count   = out_faults_q;

endmodule

// ===== rtl/core/second_chance_page_replacement.sv =====
// Second-chance (clock) page replacement, one page reference per transaction.
// Order: a hit passes through idle, lookup, resolve and emit; a fault goes from resolve
// to sweep, which clears each set use bit under the hand before loading, then to emit.
// Emit waits while the output register is full and stalled. A new reference is taken
// only in idle, once the previous result has moved into the output register.
// Reset clears valid and use bits, hand and fault count; num_frames resets to 16.
module second_chance_page_replacement #(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [scpr_pkg::CFG_WIDTH-1:0]       num_frames,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [PAGE_WIDTH-1:0]                page,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic [scpr_pkg::FRAME_OUT_WIDTH-1:0] frame,
	output logic                                 evicted_valid,
	output logic [PAGE_WIDTH-1:0]                evicted_page,
	output logic [scpr_pkg::FAULT_WIDTH-1:0]     fault_count
);

	scpr_pkg::cmd_t    cmd;
	scpr_pkg::status_t status;

	// The register takes a write in any cycle; it is meant to change only between transactions.
	assign cfg_ready = 1'b1;

	// Controller.
	scpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	scpr_dp #(
		.FRAMES     (FRAMES),
		.PAGE_WIDTH (PAGE_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (num_frames),
		.page_in           (page),
		.cmd               (cmd),
		.status            (status),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.out_hit           (hit),
		.out_frame         (frame),
		.out_evicted_valid (evicted_valid),
		.out_evicted_page  (evicted_page),
		.out_fault_count   (fault_count)
	);

endmodule
